// ===== design/fspd_pkg.sv =====
// Shared constants, types and register codes of the five-sample peak detector.
package fspd_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int LINE_LEN      = 5;
    localparam int MID_TAP       = LINE_LEN / 2;
    localparam int COUNT_BITS    = 16;
    localparam int HOLD_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = (SAMPLE_BITS > HOLD_BITS) ? SAMPLE_BITS : HOLD_BITS;

    typedef logic [SAMPLE_BITS-1:0]                t_sample;
    typedef logic [SAMPLE_BITS:0]                  t_sample_ext;
    typedef logic [LINE_LEN-1:0][SAMPLE_BITS-1:0]  t_line;
    typedef logic [COUNT_BITS-1:0]                 t_count;
    typedef logic [HOLD_BITS-1:0]                  t_hold;
    typedef logic [CFG_IDX_BITS-1:0]               t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0]              t_cfg_data;

    typedef struct packed {
        t_sample threshold;
        t_sample margin;
        t_hold   holdoff;
    } t_cfg;

    localparam t_cfg_idx REG_THRESHOLD = t_cfg_idx'(0);
    localparam t_cfg_idx REG_MARGIN    = t_cfg_idx'(1);
    localparam t_cfg_idx REG_HOLDOFF   = t_cfg_idx'(2);

    localparam t_sample THRESHOLD_RST = t_sample'(400);
    localparam t_sample MARGIN_RST    = t_sample'(100);
    localparam t_hold   HOLDOFF_RST   = t_hold'(0);

endpackage

// ===== design/fspd_if.sv =====
// Handshake channels: sample requests, result requests and register writes.
interface fspd_in_if;
    import fspd_pkg::*;
    logic    valid;
    logic    ready;
    t_sample sample_value;
    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface fspd_out_if;
    import fspd_pkg::*;
    logic   valid;
    logic   ready;
    logic   peak_found;
    logic   toggle_level;
    t_count peak_count;
    logic   sample_discarded;
    modport source (output valid, output peak_found, output toggle_level,
                    output peak_count, output sample_discarded, input ready);
    modport sink   (input valid, input peak_found, input toggle_level,
                    input peak_count, input sample_discarded, output ready);
endinterface

interface fspd_cfg_if;
    import fspd_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/fspd_detect.sv =====
// Peak test over one five-sample window against threshold and margin.
module fspd_detect (
    input  fspd_pkg::t_line i_window,
    input  fspd_pkg::t_cfg  i_cfg,
    output logic            o_hit
);
    import fspd_pkg::*;

    t_sample     w_mid;
    t_sample_ext w_mid_ext;
    t_sample_ext w_half_ext;
    t_sample_ext w_full_ext;
    logic [LINE_LEN-1:0] w_below;

    assign w_mid      = i_window[MID_TAP];
    assign w_mid_ext  = {1'b0, w_mid};
    assign w_half_ext = {2'b00, i_cfg.margin[SAMPLE_BITS-1:1]};
    assign w_full_ext = {1'b0, i_cfg.margin};

    // x < mid - d, with a negative difference never met: x + d < mid
    always_comb begin
        for (int k = 0; k < LINE_LEN; k++) begin
            if (k == MID_TAP) begin
                w_below[k] = 1'b1;
            end else if (k == MID_TAP - 1 || k == MID_TAP + 1) begin
                w_below[k] = ({1'b0, i_window[k]} + w_half_ext) < w_mid_ext;
            end else begin
                w_below[k] = ({1'b0, i_window[k]} + w_full_ext) < w_mid_ext;
            end
        end
    end

    assign o_hit = (i_cfg.threshold != '0) && (w_mid > i_cfg.threshold) && (&w_below);

endmodule

// ===== design/five_sample_peak_detector_unit.sv =====
// Top level of the five-sample peak detector.
// Path: an accepted sample request is loaded into the input register; when the output
// advances, its result is loaded into the result register and offered from there.
// Throughput: one sample per cycle while results are taken; the input register
// holds one request while the output stalls.
// Reset: synchronous active low; clears the sample line, toggle, count and holdoff,
// and loads threshold 400, margin 100, holdoff 0.
module five_sample_peak_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fspd_in_if.sink     i_sample,
    fspd_cfg_if.sink    i_cfg,
    fspd_out_if.source  o_result
);
    import fspd_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_sample r_in_sample;
    t_line   r_line;
    logic    r_toggle;
    t_count  r_count;
    t_hold   r_holdoff;
    logic    r_out_valid;
    logic    r_out_found;
    logic    r_out_toggle;
    t_count  r_out_count;
    logic    r_out_dropped;

    t_line   n_line;
    logic    n_toggle;
    t_count  n_count;
    t_hold   n_holdoff;

    logic    w_advance;
    logic    w_fire;
    logic    w_drop;
    logic    w_hit;
    logic    w_found;
    logic    w_in_take;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RST;
            r_cfg.margin    <= MARGIN_RST;
            r_cfg.holdoff   <= HOLDOFF_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_THRESHOLD: r_cfg.threshold <= i_cfg.data[SAMPLE_BITS-1:0];
                REG_MARGIN:    r_cfg.margin    <= i_cfg.data[SAMPLE_BITS-1:0];
                REG_HOLDOFF:   r_cfg.holdoff   <= i_cfg.data[HOLD_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_advance      = !r_out_valid || o_result.ready;
    assign i_sample.ready = !r_in_valid || w_advance;
    assign w_in_take      = i_sample.valid && i_sample.ready;
    assign w_fire         = r_in_valid && w_advance;
    assign w_drop         = (r_holdoff != '0);

    // shift the newest sample in at the top of the line
    always_comb begin
        for (int k = 0; k < LINE_LEN - 1; k++) begin
            n_line[k] = r_line[k+1];
        end
        n_line[LINE_LEN-1] = r_in_sample;
    end

    fspd_detect u_detect (
        .i_window (n_line),
        .i_cfg    (r_cfg),
        .o_hit    (w_hit)
    );

    assign w_found  = !w_drop && w_hit;
    assign n_toggle = r_toggle ^ w_found;
    assign n_count  = (w_found && (r_count != '1)) ? r_count + t_count'(1) : r_count;

    always_comb begin
        if (w_drop) begin
            n_holdoff = r_holdoff - t_hold'(1);
        end else if (w_hit) begin
            n_holdoff = r_cfg.holdoff;
        end else begin
            n_holdoff = r_holdoff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_sample <= i_sample.sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line    <= '0;
            r_toggle  <= 1'b0;
            r_count   <= '0;
            r_holdoff <= '0;
        end else if (w_fire) begin
            if (!w_drop) begin
                r_line <= n_line;
            end
            r_toggle  <= n_toggle;
            r_count   <= n_count;
            r_holdoff <= n_holdoff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_found   <= w_found;
            r_out_toggle  <= n_toggle;
            r_out_count   <= n_count;
            r_out_dropped <= w_drop;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.peak_found       = r_out_found;
    assign o_result.toggle_level     = r_out_toggle;
    assign o_result.peak_count       = r_out_count;
    assign o_result.sample_discarded = r_out_dropped;

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> r_count >= $past(r_count))
        else $error("peak count went backwards");

    a_toggle_on_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_toggle ^ $past(r_toggle)) == $past(w_fire && w_found))
        else $error("toggle changed without a detected peak");

    a_holdoff_freezes_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_drop) |=> r_line == $past(r_line))
        else $error("sample line shifted during holdoff");

    a_drop_no_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_drop) |=> (r_out_dropped && !r_out_found))
        else $error("dropped sample reported as peak");

endmodule
